// ===== rtl/wga_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wga_pkg
// Types, constants and the saturating add shared by the Gram accumulator.
// ----------------------------------------------------------------------------
package wga_pkg;

  localparam int LANES   = 8;
  localparam int TAG_W   = 4;
  localparam int ACC_W   = 64;
  localparam int PROD_W  = 48;
  localparam int OPND_W  = 32;
  localparam logic [TAG_W-1:0] TAG_Y = TAG_W'(LANES);   // cross / target column

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ACC   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [6:0] IDX_CROSS = 7'd64;
  localparam logic [6:0] IDX_YY    = 7'd72;
  localparam logic [6:0] IDX_ROWS  = 7'd73;
  localparam logic [6:0] IDX_WY    = 7'd74;

  localparam logic [15:0] ONE_Q8 = 16'd256;

  // operand handed along the chain of cells
  typedef struct packed {
    logic                     v;
    logic [TAG_W-1:0]         tag;
    logic signed [OPND_W-1:0] b;
  } link_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [ACC_W-1:0] sum;
  } sat_t;

  function automatic sat_t sat_add(input logic signed [ACC_W-1:0] acc,
                                   input logic signed [ACC_W-1:0] p);
    sat_t r;
    logic signed [ACC_W-1:0] s;
    s = acc + p;
    r.ovf = (acc[ACC_W-1] == p[ACC_W-1]) && (s[ACC_W-1] != acc[ACC_W-1]);
    if (r.ovf) begin
      r.sum = acc[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r.sum = s;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wga_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wga_cell
// One Gram row: multiplies its own lane by each passing operand and keeps
// the upper-triangle sums of its row plus its cross sum.
// ----------------------------------------------------------------------------
module wga_cell
  import wga_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    clear,
  input  wire logic signed [15:0]      x,
  input  wire link_t                   link_in,
  output link_t                        link_out,
  input  wire logic [TAG_W-1:0]        rd_col,
  output logic signed [ACC_W-1:0]      rd_value,
  output logic                         sat
);

  localparam int DEPTH = LANES + 1;

  logic                     pv;
  logic [TAG_W-1:0]         ptag;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc [DEPTH];
  sat_t                     add;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.v <= 1'b0;
      pv         <= 1'b0;
    end else begin
      link_out.v <= link_in.v;
      pv         <= link_in.v && (link_in.tag >= TAG_W'(INDEX));
    end
    link_out.tag <= link_in.tag;
    link_out.b   <= link_in.b;
    ptag         <= link_in.tag;
    prod         <= x * link_in.b;
  end

  assign add = sat_add(acc[ptag], ACC_W'(prod));
  assign sat = pv && add.ovf;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int k = 0; k < DEPTH; k++) acc[k] <= '0;
    end else if (pv) begin
      acc[ptag] <= add.sum;
    end
  end

  assign rd_value = (rd_col <= TAG_Y) ? acc[rd_col] : '0;

endmodule
`default_nettype wire

// ===== rtl/weighted_gram_accumulator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_gram_accumulator_top
// Weighted normal-equation accumulation over a chain of Gram row cells.
// ----------------------------------------------------------------------------
// Row request: the next request waits until the operand chain drains:
//   FEATURE_COUNT+1 operands enter cell 0 one a cycle and must pass every
//   cell, plus the issue, product and add stages. One row in flight at a
//   time.
// Read request: result registered at the accepting edge, taken as soon as
//   the chain is idle and the output register is free.
// Reset (rst, synchronous): all sums, count and flag cleared, weighted mode 1.
// ----------------------------------------------------------------------------
module weighted_gram_accumulator_top
  import wga_pkg::*;
#(
  parameter int FEATURE_COUNT = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,   // weighted_mode
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // s_tdata, low bit up: feature_0..feature_7 (16 each), target (16),
  // weight (16), entry_index (7), one pad bit
  input  wire logic [167:0] s_tdata,
  input  wire logic [1:0]   s_tuser,     // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tdata, low bit up: entry_value (64), overflowed (1), seven pad bits
  output logic [71:0]       m_tdata
);

  localparam int LAST   = 2 * FEATURE_COUNT + 1;
  localparam int STEP_W = $clog2(LAST + 1);

  // request fields
  logic [1:0]         command;
  logic signed [15:0] feat_in [LANES];
  logic signed [15:0] target_in;
  logic signed [15:0] weight_in;
  logic [6:0]         entry_index;

  assign command = s_tuser;
  always_comb begin
    for (int k = 0; k < LANES; k++) feat_in[k] = s_tdata[16*k +: 16];
  end
  assign target_in   = s_tdata[143:128];
  assign weight_in   = s_tdata[159:144];
  assign entry_index = s_tdata[166:160];

  logic weighted_mode;
  always_ff @(posedge clk) begin
    if (rst) weighted_mode <= 1'b1;
    else if (cfg_we) weighted_mode <= cfg_wdata;
  end

  // handshake
  logic accept, row_req, start_req, read_req, busy;
  assign s_tready  = !busy && (!m_tvalid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign start_req = accept && (command == CMD_START);
  assign row_req   = accept && ((command == CMD_START) || (command == CMD_ACC));
  assign read_req  = accept && (command == CMD_READ);

  // latched row and effective weight
  logic signed [15:0] x   [LANES];
  logic signed [15:0] y;
  logic [16:0]        we;
  logic [16:0]        w_abs;

  assign w_abs = weight_in[15] ? 17'(-$signed({weight_in[15], weight_in}))
                               : {1'b0, weight_in};

  always_ff @(posedge clk) begin
    if (row_req) begin
      for (int k = 0; k < LANES; k++) begin
        x[k] <= (k < FEATURE_COUNT) ? feat_in[k] : '0;
      end
      y  <= target_in;
      we <= weighted_mode ? (w_abs + 17'd1) : {1'b0, ONE_Q8};
    end
  end

  // sequencer: issue operand columns then let the chain drain
  logic [STEP_W-1:0] step;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (row_req) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step == STEP_W'(LAST)) busy <= 1'b0;
      step <= step + STEP_W'(1);
    end
  end

  logic               issuing;
  logic               y_col;
  logic signed [15:0] xsel;
  logic signed [33:0] bprod;
  link_t              issue;

  assign issuing = busy && (step <= STEP_W'(FEATURE_COUNT));
  assign y_col   = (step == STEP_W'(FEATURE_COUNT));
  assign xsel    = y_col ? y : x[step[2:0]];
  assign bprod   = xsel * $signed({1'b0, we});

  always_ff @(posedge clk) begin
    if (rst) issue.v <= 1'b0;
    else issue.v <= issuing;
    issue.tag <= y_col ? TAG_Y : TAG_W'(step);
    issue.b   <= bprod[OPND_W-1:0];
  end

  // chain of cells, one per Gram row
  link_t                   link   [FEATURE_COUNT+1];
  logic signed [ACC_W-1:0] rd_val [LANES];
  logic [LANES-1:0]        cell_sat;
  logic [TAG_W-1:0]        rd_col;

  assign link[0] = issue;

  for (genvar g = 0; g < LANES; g++) begin : g_cell
    if (g < FEATURE_COUNT) begin : g_on
      wga_cell #(.INDEX(g)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (start_req),
        .x        (x[g]),
        .link_in  (link[g]),
        .link_out (link[g+1]),
        .rd_col   (rd_col),
        .rd_value (rd_val[g]),
        .sat      (cell_sat[g])
      );
    end else begin : g_off
      assign rd_val[g]   = '0;
      assign cell_sat[g] = 1'b0;
    end
  end

  // scalar tail: y'Wy and sum of w*y from the target operand
  logic                     tv;
  logic signed [PROD_W-1:0] tprod;
  logic signed [OPND_W-1:0] tb;
  logic signed [ACC_W-1:0]  yy_sum, wy_sum;
  sat_t                     yy_add, wy_add;

  always_ff @(posedge clk) begin
    if (rst) tv <= 1'b0;
    else tv <= issue.v && (issue.tag == TAG_Y);
    tprod <= y * issue.b;
    tb    <= issue.b;
  end

  assign yy_add = sat_add(yy_sum, ACC_W'(tprod));
  assign wy_add = sat_add(wy_sum, ACC_W'(tb));

  always_ff @(posedge clk) begin
    if (rst || start_req) begin
      yy_sum <= '0;
      wy_sum <= '0;
    end else if (tv) begin
      yy_sum <= yy_add.sum;
      wy_sum <= wy_add.sum;
    end
  end

  // row count and sticky saturation flag
  logic [31:0] rows;
  logic        flag, rows_full;
  assign rows_full = row_req && !start_req && (rows == 32'hFFFF_FFFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '0;
      flag <= 1'b0;
    end else begin
      if (start_req) rows <= 32'd1;
      else if (row_req && !rows_full) rows <= rows + 32'd1;
      if (start_req) flag <= 1'b0;
      else if (rows_full || (|cell_sat) || (tv && (yy_add.ovf || wy_add.ovf))) flag <= 1'b1;
    end
  end

  // read selection: mirror the lower triangle onto the stored upper one
  logic [2:0]              gi, gj, lo, hi;
  logic signed [ACC_W-1:0] rd_data;

  assign gi     = entry_index[5:3];
  assign gj     = entry_index[2:0];
  assign lo     = (gi > gj) ? gj : gi;
  assign hi     = (gi > gj) ? gi : gj;
  assign rd_col = entry_index[6] ? TAG_Y : TAG_W'(hi);

  always_comb begin
    if (entry_index < IDX_CROSS) begin
      rd_data = (32'(hi) < FEATURE_COUNT) ? rd_val[lo] : '0;
    end else if (entry_index < IDX_YY) begin
      rd_data = (32'(gj) < FEATURE_COUNT) ? rd_val[gj] : '0;
    end else if (entry_index == IDX_YY) begin
      rd_data = yy_sum;
    end else if (entry_index == IDX_ROWS) begin
      rd_data = {32'd0, rows};
    end else if (entry_index == IDX_WY) begin
      rd_data = wy_sum;
    end else begin
      rd_data = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (read_req) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (read_req) m_tdata <= {7'd0, flag, rd_data};
  end

endmodule
`default_nettype wire

// ===== rtl/wga_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wga_checker
// Port-level checks for the Gram accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module wga_checker
  import wga_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [1:0]   s_tuser,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [71:0]  m_tdata
);

  // a held result keeps its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // a row request blocks the next request while the chain works
  a_row_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_START || s_tuser == CMD_ACC) |=> !s_tready)
    else $error("request taken while a row is in flight");

  // a read request shows its result next cycle
  a_read: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_READ |=> m_tvalid)
    else $error("read gave no result");

  // only reads produce results
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !(s_tvalid && s_tready && s_tuser == CMD_READ) |=> !m_tvalid)
    else $error("result without a read");

endmodule

bind weighted_gram_accumulator_top wga_checker u_wga_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
